// ----- sv/evlf_pkg.sv -----
// Package for the encoded value length framer: parse phases, status codes, type byte constants.
`default_nettype none

package evlf_pkg;

    // Parse phase of the framer
    typedef enum logic [1:0] {
        PH_TYPE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BLOB   = 2'd2,
        PH_TEXT   = 2'd3
    } t_phase;

    // Result status codes
    typedef enum logic [1:0] {
        ST_BUSY     = 2'd0,
        ST_DONE     = 2'd1,
        ST_BAD_TYPE = 2'd2,
        ST_TOO_DEEP = 2'd3
    } t_status;

    // Type byte decoding
    localparam logic [7:0] INT_MARK     = 8'h80;
    localparam logic [7:0] BLOB_MASK    = 8'hf8;
    localparam logic [7:0] BLOB_CODE    = 8'h98;
    localparam logic [7:0] INT_LEN_MASK = 8'h07;

    localparam logic [7:0] CH_TRUE   = 8'h54; // 'T'
    localparam logic [7:0] CH_FALSE  = 8'h46; // 'F'
    localparam logic [7:0] CH_NULL   = 8'h30; // '0'
    localparam logic [7:0] CH_FLOAT  = 8'h66; // 'f'
    localparam logic [7:0] CH_DOUBLE = 8'h67; // 'g'
    localparam logic [7:0] CH_STRING = 8'h73; // 's'
    localparam logic [7:0] CH_IDENT  = 8'h69; // 'i'
    localparam logic [7:0] CH_TUPLE  = 8'h74; // 't'
    localparam logic [7:0] CH_LIST   = 8'h6c; // 'l'
    localparam logic [7:0] CH_DICT   = 8'h64; // 'd'
    localparam logic [7:0] CH_END    = 8'h45; // 'E'

    localparam logic [3:0] FLOAT_BYTES  = 4'd4;
    localparam logic [3:0] DOUBLE_BYTES = 4'd8;

endpackage

`default_nettype wire

// ----- sv/encoded_value_length_framer_top.sv -----
// Encoded value length framer: one byte in, one framing result out, per cycle while results are taken.
`default_nettype none

// Takes one byte of a binary-encoded value stream per request on the slave
// stream and returns one result per byte on the master stream: a status
// (in progress, top-level value complete, invalid type byte, nesting too
// deep), the length of the current top-level value so far including this
// byte (saturating) and the container depth after the byte. Each byte's
// decode runs between the input port and a single result register, so a
// byte is accepted in every cycle in which the result register is empty or
// being drained. After an invalid type byte or a too-deep opener the parser
// returns to its reset state. MAX_DEPTH bounds the nesting depth (capped at
// 255); LENGTH_BITS sets the width of the internal byte counter.
module encoded_value_length_framer_top
    import evlf_pkg::*;
#(
    parameter int MAX_DEPTH   = 255,
    parameter int LENGTH_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Slave stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,  // [7:0] data_byte
    // Master stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata   // [1:0] frame_status, [33:2] value_length,
                                              // [41:34] nest_depth, [47:42] zero
);

    localparam int DEPTH_LIMIT = (MAX_DEPTH < 255) ? MAX_DEPTH : 255;
    localparam int CW          = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

    // Parser state
    t_phase                   r_phase, n_phase;
    logic [3:0]               r_header_left, n_header_left;
    logic [63:0]              r_blob_remaining, n_blob_remaining;
    logic                     r_blob_flag, n_blob_flag;
    logic [7:0]               r_nest, n_nest;
    logic [LENGTH_BITS-1:0]   r_bytes_seen, n_bytes_seen;

    // Result register
    logic                     r_out_valid;
    t_status                  r_status, n_status;
    logic [31:0]              r_value_length, n_value_length;
    logic [7:0]               r_nest_depth;

    // Decode of one byte before error/completion handling
    t_phase                   w_phase;
    logic [3:0]               w_header_left;
    logic [63:0]              w_blob_remaining;
    logic                     w_blob_flag;
    logic [7:0]               w_nest;
    logic                     w_done;
    logic                     w_bad_type;
    logic                     w_too_deep;
    logic [3:0]               w_hl_dec;
    logic [63:0]              w_rem_dec;
    logic [63:0]              w_rem_shift;

    logic [LENGTH_BITS-1:0]   w_count;
    logic [CW-1:0]            w_count_ext;
    logic [7:0]               w_byte;
    logic                     w_in_acc;

    assign w_byte          = i_s_axis_tdata;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    // Saturating byte count including this byte
    assign w_count     = (&r_bytes_seen) ? r_bytes_seen : r_bytes_seen + 1'b1;
    assign w_count_ext = CW'(w_count);
    assign w_hl_dec    = (r_header_left != 4'd0) ? r_header_left - 4'd1 : r_header_left;
    assign w_rem_dec   = (r_blob_remaining != 64'd0) ? r_blob_remaining - 64'd1
                                                     : r_blob_remaining;
    assign w_rem_shift = {r_blob_remaining[55:0], w_byte};

    // Next-phase decode
    always_comb begin
        w_phase          = r_phase;
        w_header_left    = r_header_left;
        w_blob_remaining = r_blob_remaining;
        w_blob_flag      = r_blob_flag;
        w_nest           = r_nest;
        w_done           = 1'b0;
        w_bad_type       = 1'b0;
        w_too_deep       = 1'b0;
        unique case (r_phase)
            PH_HEADER: begin
                if (r_blob_flag) begin
                    w_blob_remaining = w_rem_shift;
                end
                w_header_left = w_hl_dec;
                if (w_hl_dec == 4'd0) begin
                    if (r_blob_flag && (w_rem_shift != 64'd0)) begin
                        w_phase = PH_BLOB;
                    end else begin
                        w_done = 1'b1;
                    end
                    w_blob_flag = 1'b0;
                end
            end
            PH_BLOB: begin
                w_blob_remaining = w_rem_dec;
                if (w_rem_dec == 64'd0) begin
                    w_done = 1'b1;
                end
            end
            PH_TEXT: begin
                if (w_byte == 8'd0) begin
                    w_done = 1'b1;
                end
            end
            PH_TYPE: begin
                priority if ((w_byte & INT_MARK) != 8'd0) begin
                    w_header_left    = (w_byte[3:0] & INT_LEN_MASK[3:0]) + 4'd1;
                    w_blob_flag      = ((w_byte & BLOB_MASK) == BLOB_CODE);
                    w_blob_remaining = 64'd0;
                    w_phase          = PH_HEADER;
                end else if (w_byte == CH_TRUE || w_byte == CH_FALSE
                             || w_byte == CH_NULL) begin
                    w_done = 1'b1;
                end else if (w_byte == CH_FLOAT || w_byte == CH_DOUBLE) begin
                    w_header_left = (w_byte == CH_FLOAT) ? FLOAT_BYTES : DOUBLE_BYTES;
                    w_blob_flag   = 1'b0;
                    w_phase       = PH_HEADER;
                end else if (w_byte == CH_STRING || w_byte == CH_IDENT) begin
                    w_phase = PH_TEXT;
                end else if (w_byte == CH_TUPLE || w_byte == CH_LIST
                             || w_byte == CH_DICT) begin
                    if (r_nest >= 8'(DEPTH_LIMIT)) begin
                        w_too_deep = 1'b1;
                    end else begin
                        w_nest = r_nest + 8'd1;
                    end
                end else if (w_byte == CH_END && r_nest != 8'd0) begin
                    w_nest = r_nest - 8'd1;
                    w_done = 1'b1;
                end else begin
                    w_bad_type = 1'b1;
                end
            end
        endcase
    end

    // Error and completion handling, result fields
    always_comb begin
        n_phase          = w_phase;
        n_header_left    = w_header_left;
        n_blob_remaining = w_blob_remaining;
        n_blob_flag      = w_blob_flag;
        n_nest           = w_nest;
        n_bytes_seen     = w_count;
        n_status         = ST_BUSY;
        n_value_length   = (w_count_ext > CW'(32'hffff_ffff)) ? 32'hffff_ffff
                                                              : w_count_ext[31:0];
        priority if (w_bad_type || w_too_deep) begin
            n_phase          = PH_TYPE;
            n_header_left    = 4'd0;
            n_blob_remaining = 64'd0;
            n_blob_flag      = 1'b0;
            n_nest           = 8'd0;
            n_bytes_seen     = '0;
            n_status         = w_too_deep ? ST_TOO_DEEP : ST_BAD_TYPE;
        end else if (w_done) begin
            n_phase = PH_TYPE;
            if (w_nest == 8'd0) begin
                n_status     = ST_DONE;
                n_bytes_seen = '0;
            end
        end else begin
            n_phase = w_phase;
        end
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_TYPE;
            r_header_left    <= 4'd0;
            r_blob_remaining <= 64'd0;
            r_blob_flag      <= 1'b0;
            r_nest           <= 8'd0;
            r_bytes_seen     <= '0;
        end else if (w_in_acc) begin
            r_phase          <= n_phase;
            r_header_left    <= n_header_left;
            r_blob_remaining <= n_blob_remaining;
            r_blob_flag      <= n_blob_flag;
            r_nest           <= n_nest;
            r_bytes_seen     <= n_bytes_seen;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_status       <= n_status;
            r_value_length <= n_value_length;
            r_nest_depth   <= n_nest;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_nest_depth, r_value_length, r_status};

    // Checks
    a_err_clears_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_BAD_TYPE || r_status == ST_TOO_DEEP))
        |-> (r_nest_depth == 8'd0 && r_nest == 8'd0))
        else $error("error result with nonzero depth");

    a_done_top_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_DONE) |-> (r_nest_depth == 8'd0))
        else $error("completion reported inside a container");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_out_valid)
        else $error("accepted byte produced no result");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> (r_out_valid && $stable(o_m_axis_tdata)
        && $stable(r_phase) && $stable(r_bytes_seen)))
        else $error("stalled result or parser state changed");

endmodule

`default_nettype wire
